FILE: rtl/core/bfe_pkg.sv
// Shared types, constants and helpers for the Blowfish block encryptor.
package bfe_pkg;

    localparam int ROUNDS  = 16;
    localparam int P_WORDS = 18;
    localparam int P_IDX_W = 5;
    localparam int Q_DEPTH = 2;

    // input action codes
    localparam logic [1:0] ACT_ENCRYPT = 2'd0;
    localparam logic [1:0] ACT_LOAD_P  = 2'd1;
    localparam logic [1:0] ACT_LOAD_S  = 2'd2;

    typedef enum logic [1:0] {
        KIND_ENC    = 2'd0,
        KIND_LOAD_P = 2'd1,
        KIND_LOAD_S = 2'd2
    } cmd_kind_t;

    // data_l carries the table word on loads
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] data_l;
        logic [31:0] data_r;
        logic [9:0]  index;
    } cmd_t;

    function automatic logic [31:0] byte_rev(input logic [31:0] v);
        byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: rtl/core/bfe_front.sv
// Front end: decodes input items into commands, drops no-op items.
module bfe_front (
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    s_axis_tuser,   // action
    input  logic [111:0]  s_axis_tdata,   // left_half, right_half, table_index, table_word
    input  logic          swap,
    input  logic          q_full,
    output logic          push,
    output bfe_pkg::cmd_t cmd
);
    import bfe_pkg::*;

    logic [31:0] left_half;
    logic [31:0] right_half;
    logic [9:0]  table_index;
    logic [31:0] table_word;
    logic        keep;

    assign left_half   = s_axis_tdata[31:0];
    assign right_half  = s_axis_tdata[63:32];
    assign table_index = s_axis_tdata[73:64];
    assign table_word  = s_axis_tdata[105:74];

    assign s_axis_tready = !q_full;

    always_comb
    begin
        cmd.index  = table_index;
        cmd.data_l = table_word;
        cmd.data_r = right_half;
        cmd.kind   = KIND_LOAD_S;
        keep       = 1'b0;
        unique case (s_axis_tuser)
            ACT_ENCRYPT:
            begin
                cmd.kind   = KIND_ENC;
                cmd.data_l = swap ? byte_rev(left_half) : left_half;
                cmd.data_r = swap ? byte_rev(right_half) : right_half;
                keep       = 1'b1;
            end
            ACT_LOAD_P:
            begin
                cmd.kind = KIND_LOAD_P;
                keep     = (table_index < 10'(P_WORDS));   // out-of-range P index ignored
            end
            ACT_LOAD_S:
            begin
                cmd.kind = KIND_LOAD_S;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_axis_tvalid && !q_full && keep;

endmodule

FILE: rtl/core/bfe_queue.sv
// Small command queue between front and back ends.
module bfe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output bfe_pkg::cmd_t q_cmd
);
    import bfe_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [0:Q_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/bfe_back.sv
// Back end: subkey tables, round engine and output register.
module bfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          swap,
    input  logic          q_valid,
    input  bfe_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata   // cipher_left, cipher_right
);
    import bfe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DRAIN = 3'b100
    } back_state_t;

    localparam logic [3:0] LAST_ROUND = 4'(ROUNDS - 1);

    back_state_t state_reg, state_next;
    logic [3:0]  round_reg, round_next;
    logic [31:0] l_reg, l_next;
    logic [31:0] r_reg, r_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_l_reg, out_r_reg;

    logic [31:0] p_reg    [0:P_WORDS-1];
    logic [31:0] s_mem    [0:3][0:255];
    logic [31:0] s_rd_reg [0:3];

    logic               p_we, s_we, load_out;
    logic [P_IDX_W-1:0] p_idx;
    logic [31:0]        f_val, new_r;

    // F function on the registered S-box words
    assign f_val = ((s_rd_reg[0] + s_rd_reg[1]) ^ s_rd_reg[2]) + s_rd_reg[3];
    assign new_r = r_reg ^ f_val;
    assign p_idx = {1'b0, round_reg} + P_IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        pop        = 1'b0;
        p_we       = 1'b0;
        s_we       = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (q_cmd.kind)
                        KIND_ENC:
                        begin
                            l_next     = q_cmd.data_l ^ p_reg[0];
                            r_next     = q_cmd.data_r;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                        KIND_LOAD_P: p_we = 1'b1;
                        KIND_LOAD_S: s_we = 1'b1;
                        default:     pop  = 1'b1;
                    endcase
                end
            end
            ST_ROUND:
            begin
                if (round_reg != LAST_ROUND)
                begin
                    l_next     = new_r ^ p_reg[p_idx];
                    r_next     = l_reg;
                    round_next = round_reg + 1'b1;
                end
                else
                begin
                    // final exchange undone, output whitening applied
                    l_next     = swap ? byte_rev(l_reg ^ p_reg[P_WORDS-1])
                                      : (l_reg ^ p_reg[P_WORDS-1]);
                    r_next     = swap ? byte_rev(new_r ^ p_reg[P_WORDS-2])
                                      : (new_r ^ p_reg[P_WORDS-2]);
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        r_reg <= r_next;
        if (load_out)
        begin
            out_l_reg <= l_reg;
            out_r_reg <= r_reg;
        end
        if (p_we)
        begin
            p_reg[q_cmd.index[P_IDX_W-1:0]] <= q_cmd.data_l;
        end
    end

    // four S-box memories, one write and one read port each; read address is
    // the byte of the next round input
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (s_we && (q_cmd.index[9:8] == 2'(b)))
            begin
                s_mem[b][q_cmd.index[7:0]] <= q_cmd.data_l;
            end
            s_rd_reg[b] <= s_mem[b][l_next[8*(3-b) +: 8]];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while busy");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_DRAIN))
        else $error("last round did not end in drain");

    a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("output loaded outside drain");

endmodule

FILE: rtl/core/blowfish_block_encrypt_core.sv
// Top level of the Blowfish block encryptor with loadable subkey tables.
//
// Input stream (s_axis_*): tuser carries the action, tdata the block halves,
// the table index and the table word. Action encrypt yields one output item;
// P and S loads yield none, as do P loads with index 18 or more and action 3.
// The key schedule is external: the host loads all 18 P words and all 1024
// S words (box number * 256 + entry) before the first encrypt.
// Output stream (m_axis_*): tdata carries cipher_left (low) and cipher_right.
// cfg_we/cfg_wdata write swap_bytes; write it only while the block is idle.
//
// Flow: the front decodes an item in the accept cycle into a two-entry
// command queue. The back end takes one command at a time: a load is written
// as it is popped; an encrypt runs an issue step, 16 rounds at one round
// per cycle through the registered S-box reads, and a drain step into the
// output register that waits while that register still holds an unread
// result. The next command is taken only once the encrypt has drained.
// A stalled receiver holds the result in the output register; the queue
// keeps accepting until full. Reset empties the queue and the output and
// clears swap_bytes; table contents are left as they are.
module blowfish_block_encrypt_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // action
    input  logic [111:0] s_axis_tdata,   // left_half, right_half, table_index, table_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // cipher_left, cipher_right
    input  logic         cfg_we,
    input  logic         cfg_wdata       // swap_bytes
);
    import bfe_pkg::*;

    logic swap_reg, swap_next;
    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, q_cmd;

    // swap_bytes register
    assign swap_next = cfg_we ? cfg_wdata : swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
        end
        else
        begin
            swap_reg <= swap_next;
        end
    end

    // decode and drop no-op items
    bfe_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .swap          (swap_reg),
        .q_full        (q_full),
        .push          (q_push),
        .cmd           (push_cmd)
    );

    // decouples accept from the round engine
    bfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // tables, 16-round engine, output register
    bfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .swap          (swap_reg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Blowfish block encryptor: stream stimulus against a predictor.
module tb;
    import bfe_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 9;
    localparam int          DRAIN_CYCLES = 48;     // two queued commands plus one encrypt
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          MAX_PRINTED  = 200;
    localparam logic [1:0]  ACT_NONE     = 2'd3;   // unused action code

    typedef struct {
        logic [1:0]  action;
        logic [31:0] left;
        logic [31:0] right;
        logic [9:0]  index;
        logic [31:0] word;
    } bf_item_t;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
    } cipher_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;     // action
    logic [111:0] s_axis_tdata = '0;     // left_half, right_half, table_index, table_word
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;          // cipher_left, cipher_right
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;      // swap_bytes

    // predictor state
    logic [31:0]  p_tbl [P_WORDS];
    logic [31:0]  s_tbl [1024];
    logic         swap_cfg = 1'b0;
    cipher_t      cipher_expected[$];

    int           send_gap = 0;
    int           recv_gap = 0;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           err_count = 0;
    int           cycle_count = 0;

    blowfish_block_encrypt_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0d] mismatch: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic logic [31:0] flip_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] x);
        logic [31:0] acc;
        acc = s_tbl[{2'd0, x[31:24]}] + s_tbl[{2'd1, x[23:16]}];
        acc ^= s_tbl[{2'd2, x[15:8]}];
        acc += s_tbl[{2'd3, x[7:0]}];
        return acc;
    endfunction

    function automatic cipher_t encipher_block(input logic [31:0] l, input logic [31:0] r);
        logic [31:0] xl;
        logic [31:0] xr;
        logic [31:0] t;
        cipher_t     res;
        xl = swap_cfg ? flip_bytes(l) : l;
        xr = swap_cfg ? flip_bytes(r) : r;
        for (int k = 0; k < ROUNDS; k++)
        begin
            xl ^= p_tbl[k];
            xr ^= round_mix(xl);
            t  = xl;
            xl = xr;
            xr = t;
        end
        // last exchange is undone before whitening
        t  = xl;
        xl = xr;
        xr = t;
        xr ^= p_tbl[16];
        xl ^= p_tbl[17];
        res.left  = swap_cfg ? flip_bytes(xl) : xl;
        res.right = swap_cfg ? flip_bytes(xr) : xr;
        return res;
    endfunction

    // update tables or queue the expected cipher for an accepted item
    task automatic absorb_item(input bf_item_t it);
        case (it.action)
            ACT_ENCRYPT: cipher_expected.push_back(encipher_block(it.left, it.right));
            ACT_LOAD_P:  if (it.index < P_WORDS) p_tbl[it.index[P_IDX_W-1:0]] = it.word;
            ACT_LOAD_S:  s_tbl[it.index] = it.word;
            default:     ;
        endcase
    endtask

    task automatic send_item(input bf_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {6'b0, it.word, it.index, it.right, it.left};
        do @(posedge clk); while (!s_axis_tready);
        absorb_item(it);
    endtask

    // lower valid, wait for every cipher, then let trailing loads retire
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (cipher_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_swap(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        swap_cfg  = v;
    endtask

    function automatic bf_item_t mk_item(input logic [1:0] act, input logic [31:0] l,
                                         input logic [31:0] r, input logic [9:0] idx,
                                         input logic [31:0] w);
        bf_item_t it;
        it.action = act;
        it.left   = l;
        it.right  = r;
        it.index  = idx;
        it.word   = w;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly encrypts once the tables are full, with reloads and noise mixed in
    function automatic bf_item_t rand_item();
        bf_item_t    it;
        int unsigned pick;
        it   = mk_item(ACT_ENCRYPT, rand_word(), rand_word(), 10'($urandom), $urandom);
        pick = $urandom_range(99);
        if (pick < 60)
            it.action = ACT_ENCRYPT;
        else if (pick < 78)
            it.action = ACT_LOAD_S;
        else if (pick < 88)
        begin
            it.action = ACT_LOAD_P;
            it.index  = 10'($urandom_range(P_WORDS - 1));
        end
        else if (pick < 94)
        begin
            // out-of-range P index is dropped
            it.action = ACT_LOAD_P;
            it.index  = 10'($urandom_range(1023, P_WORDS));
        end
        else
            it.action = ACT_NONE;
        it.word = rand_word();
        return it;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_expected.size() == 0)
                report_error($sformatf("unexpected cipher %h", m_axis_tdata));
            else
            begin
                want = cipher_expected.pop_front();
                if (m_axis_tdata[31:0] !== want.left)
                    report_error($sformatf("cipher_left got %h want %h",
                                           m_axis_tdata[31:0], want.left));
                if (m_axis_tdata[63:32] !== want.right)
                    report_error($sformatf("cipher_right got %h want %h",
                                           m_axis_tdata[63:32], want.right));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_gap);
    end

    // key schedule lives outside: fill every P and S word before any encrypt
    task automatic test_table_fill();
        set_swap(1'b0);
        send_gap = 10;
        recv_gap = 0;
        for (int i = 0; i < P_WORDS; i++)
            send_item(mk_item(ACT_LOAD_P, $urandom, $urandom, 10'(i), rand_word()));
        for (int i = 0; i < 1024; i++)
            send_item(mk_item(ACT_LOAD_S, $urandom, $urandom, 10'(i), rand_word()));
        wait_idle();
    endtask

    task automatic test_directed();
        send_gap = 0;
        recv_gap = 0;
        send_item(mk_item(ACT_ENCRYPT, 32'h0, 32'h0, 10'h0, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, '1, '1, '1, '1));
        send_item(mk_item(ACT_ENCRYPT, 32'h0, '1, 10'h0, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef, 10'h0, 32'h0));
        // last valid P word, then two P loads that must be dropped
        send_item(mk_item(ACT_LOAD_P, '1, '1, 10'd17, '1));
        send_item(mk_item(ACT_LOAD_P, 32'h0, 32'h0, 10'd18, 32'h1234_5678));
        send_item(mk_item(ACT_LOAD_P, 32'h0, 32'h0, 10'd1023, 32'h0));
        send_item(mk_item(ACT_NONE, '1, '1, '1, '1));
        send_item(mk_item(ACT_LOAD_S, 32'h0, 32'h0, 10'd0, '1));
        send_item(mk_item(ACT_LOAD_S, 32'h0, 32'h0, 10'd1023, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, 32'h0, 32'h0, 10'h0, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, '1, 32'h0, 10'h0, 32'h0));
        wait_idle();
        set_swap(1'b1);
        send_item(mk_item(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef, 10'h0, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, 32'h0000_00ff, 32'hff00_0000, 10'h0, 32'h0));
        send_item(mk_item(ACT_ENCRYPT, '1, '1, 10'h0, 32'h0));
        wait_idle();
    endtask

    task automatic test_random(input int s_gap, input int r_gap, input logic swap, input int n);
        set_swap(swap);
        send_gap = s_gap;
        recv_gap = r_gap;
        for (int i = 0; i < n; i++)
            send_item(rand_item());
        wait_idle();
    endtask

    // receiver stops long enough for the command queue to fill and stall input
    task automatic test_backpressure();
        send_gap = 0;
        recv_gap = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(mk_item(ACT_ENCRYPT, $urandom, $urandom, 10'h0, 32'h0));
        wait_idle();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_table_fill();
        test_directed();
        test_random(21, 46, 1'b1, 60);
        test_random(46, 21, 1'b0, 60);
        test_backpressure();
        test_random(0, 0, 1'b1, 60);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bfe_pkg.sv
rtl/core/bfe_front.sv
rtl/core/bfe_queue.sv
rtl/core/bfe_back.sv
rtl/core/blowfish_block_encrypt_core.sv
tb/tb.sv
